// ----- hw/rtl/asc_pkg.sv -----
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants for the ADC scan sequencer.
// ----------------------------------------------------------------------------
package asc_pkg;

	localparam int NumChannels = 8;
	localparam int SampleW     = 10;
	localparam int ChanW       = 3;
	localparam int MaskW       = 8;
	localparam int TakenW      = 4;
	localparam int CountW      = $clog2(NumChannels + 1);

	typedef logic [NumChannels-1:0] chan_mask_t;
	typedef logic [ChanW-1:0]       chan_t;
	typedef logic [SampleW-1:0]     sample_t;

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_CONV    = 2'd1,
		ACT_READ    = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_RUNNING = 2'd1,
		ST_DONE    = 2'd2
	} status_t;

	// channel search results handed to the top level
	typedef struct packed {
		logic              any_live;
		chan_t             first_chan;
		logic              next_found;
		chan_t             next_chan;
		logic [CountW-1:0] live_count;
	} pick_t;

	typedef struct packed {
		status_t scan_status;
		sample_t read_sample;
		chan_t   conversion_channel;
		logic    start_conversion;
	} result_t;

endpackage

// ----- hw/rtl/asc_chan_pick.sv -----
// ----------------------------------------------------------------------------
// asc_chan_pick
// Priority encoders and popcount over the live channel mask.
// ----------------------------------------------------------------------------
module asc_chan_pick (
	input  asc_pkg::chan_mask_t live_mask,
	input  asc_pkg::chan_t      active_chan,
	output asc_pkg::pick_t      pick
);
	import asc_pkg::*;

	chan_mask_t        above;
	logic [CountW-1:0] cnt;

	always_comb begin
		for (int i = 0; i < NumChannels; i++) begin
			above[i] = live_mask[i] && (ChanW'(i) > active_chan);
		end
	end

	always_comb begin
		cnt = '0;
		for (int i = 0; i < NumChannels; i++) begin
			cnt = cnt + CountW'(live_mask[i]);
		end
	end

	// scan downwards so the lowest set bit wins
	always_comb begin
		pick.first_chan = '0;
		pick.next_chan  = '0;
		for (int i = NumChannels - 1; i >= 0; i--) begin
			if (live_mask[i]) begin
				pick.first_chan = ChanW'(i);
			end
			if (above[i]) begin
				pick.next_chan = ChanW'(i);
			end
		end
		pick.any_live   = |live_mask;
		pick.next_found = |above;
		pick.live_count = cnt;
	end

endmodule

// ----- hw/rtl/adc_scan_sequencer.sv -----
// ----------------------------------------------------------------------------
// adc_scan_sequencer
// Multichannel ADC scan sequencer with per-channel sample store.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the channel enable mask. cfg_ready is
//   always high; a write while a scan is running is dropped.
//   Slave stream: s_tuser carries the action (start, conversion complete,
//   read, clear); s_tdata carries the sample and the read channel.
//   Master stream: one result beat per input beat with the conversion
//   request, the read sample and the scan status after that beat.
//   The result of an accepted input beat is registered in the result register
//   (or in the skid register while the receiver stalls); one beat per
//   cycle is sustained while the receiver keeps m_tready high.
//   A two-entry output stage (result register plus skid register) lets an
//   input beat be taken while a result waits; s_tready drops only while both
//   entries are full.
//   Reset clears the mask, the sample store, the count and the status to
//   idle, and empties the output stage.
// ----------------------------------------------------------------------------
module adc_scan_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [asc_pkg::MaskW-1:0]  cfg_data,   // channel_enable_mask
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,    // sample_value[9:0], read_channel[12:10]
	input  logic [1:0]                 s_tuser,    // action[1:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata     // start_conversion[0], conversion_channel[3:1],
	                                               // read_sample[13:4], scan_status[15:14]
);
	import asc_pkg::*;

	logic [MaskW-1:0]  mask_q;
	sample_t           store_q [NumChannels];
	chan_t             active_q;
	logic [TakenW-1:0] taken_q;
	status_t           status_q;

	result_t res, out_q, skid_q;
	logic    out_v_q, skid_v_q;

	action_t           act;
	sample_t           in_sample;
	chan_t             in_rch;
	logic              in_acc;
	logic [TakenW-1:0] taken_inc;
	logic              conv_next;
	pick_t             pick;

	chan_t             active_d;
	logic [TakenW-1:0] taken_d;
	status_t           status_d;
	logic              store_we;
	logic              store_clr;

	assign act       = action_t'(s_tuser);
	assign in_sample = s_tdata[SampleW-1:0];
	assign in_rch    = s_tdata[SampleW +: ChanW];
	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = !skid_v_q;
	assign cfg_ready = 1'b1;
	assign taken_inc = taken_q + TakenW'(1);
	// advance to the next enabled channel rather than finish the scan
	assign conv_next = (status_q == ST_RUNNING) &&
	                   (CountW'(taken_inc) < pick.live_count) && pick.next_found;

	asc_chan_pick u_pick (
		.live_mask   (mask_q[NumChannels-1:0]),
		.active_chan (active_q),
		.pick        (pick)
	);

	// next state
	always_comb begin
		active_d  = active_q;
		taken_d   = taken_q;
		status_d  = status_q;
		store_we  = 1'b0;
		store_clr = 1'b0;
		case (act)
			ACT_START: begin
				if (pick.any_live) begin
					status_d = ST_RUNNING;
					active_d = pick.first_chan;
					taken_d  = '0;
				end
			end
			ACT_CONV: begin
				if (status_q == ST_RUNNING) begin
					store_we = 1'b1;
					taken_d  = taken_inc;
					if (conv_next) begin
						active_d = pick.next_chan;
					end else begin
						status_d = ST_DONE;
					end
				end
			end
			ACT_CLEAR: begin
				store_clr = 1'b1;
				active_d  = '0;
				taken_d   = '0;
				status_d  = ST_IDLE;
			end
			default: begin
			end
		endcase
	end

	// result beat
	always_comb begin
		res = '{scan_status: status_d, read_sample: '0,
		        conversion_channel: '0, start_conversion: 1'b0};
		case (act)
			ACT_START: begin
				if (pick.any_live) begin
					res.start_conversion   = 1'b1;
					res.conversion_channel = pick.first_chan;
				end
			end
			ACT_CONV: begin
				if (conv_next) begin
					res.start_conversion   = 1'b1;
					res.conversion_channel = pick.next_chan;
				end
			end
			ACT_READ: begin
				res.read_sample = store_q[in_rch];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			active_q <= '0;
			taken_q  <= '0;
			status_q <= ST_IDLE;
			for (int i = 0; i < NumChannels; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			// hold the mask steady for the whole scan
			if (cfg_valid && cfg_ready && status_q != ST_RUNNING) begin
				mask_q <= cfg_data;
			end
			if (in_acc) begin
				active_q <= active_d;
				taken_q  <= taken_d;
				status_q <= status_d;
				for (int i = 0; i < NumChannels; i++) begin
					if (store_clr) begin
						store_q[i] <= '0;
					end else if (store_we && active_q == ChanW'(i)) begin
						store_q[i] <= in_sample;
					end
				end
			end
		end
	end

	// output register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_tready) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= in_acc;
				end
			end else if (in_acc) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = 16'(out_q);

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while result register empty");

	a_running_count: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == ST_RUNNING) |-> (CountW'(taken_q) < pick.live_count))
		else $error("scan running with all enabled channels sampled");

	a_running_active_live: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == ST_RUNNING) |-> mask_q[active_q])
		else $error("active channel not enabled during scan");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready) |=> (out_v_q && $stable(out_q)))
		else $error("result register changed under stall");

endmodule
